FILE: hdl/lbm_pkg.sv
// Package for the D3Q19 cell equilibrium block: fixed-point constants,
// sequencer state type and the lattice direction table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lbm_pkg;
    localparam int FRAC_BITS = 28;
    localparam int NDIR      = 19;
    localparam int SUM_W     = 40;
    localparam int W_W       = 29;
    localparam int K_W       = 31;

    localparam logic [1:0] CFG_W_REST = 2'd0;
    localparam logic [1:0] CFG_W_FACE = 2'd1;
    localparam logic [1:0] CFG_W_EDGE = 2'd2;
    localparam logic [1:0] CFG_INV_CS = 2'd3;

    localparam logic [1:0] WCLS_REST = 2'd0;
    localparam logic [1:0] WCLS_FACE = 2'd1;
    localparam logic [1:0] WCLS_EDGE = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD, ST_DIV, ST_UU, ST_BASE,
        ST_DOT, ST_CU, ST_CU2, ST_POLY, ST_WR, ST_FEQ, ST_EMIT
    } t_state;

    // 2-bit signed components cx, cy, cz and weight class
    typedef struct packed {
        logic signed [1:0] cx;
        logic signed [1:0] cy;
        logic signed [1:0] cz;
        logic [1:0]        wcls;
    } t_dir;

    function automatic t_dir dir_vec(input logic [4:0] d);
        t_dir r;
        case (d)
            5'd0:    r = '{ 2'sd0, -2'sd1, -2'sd1, WCLS_EDGE};
            5'd1:    r = '{-2'sd1,  2'sd0, -2'sd1, WCLS_EDGE};
            5'd2:    r = '{ 2'sd0,  2'sd0, -2'sd1, WCLS_FACE};
            5'd3:    r = '{ 2'sd1,  2'sd0, -2'sd1, WCLS_EDGE};
            5'd4:    r = '{ 2'sd0,  2'sd1, -2'sd1, WCLS_EDGE};
            5'd5:    r = '{-2'sd1, -2'sd1,  2'sd0, WCLS_EDGE};
            5'd6:    r = '{ 2'sd0, -2'sd1,  2'sd0, WCLS_FACE};
            5'd7:    r = '{ 2'sd1, -2'sd1,  2'sd0, WCLS_EDGE};
            5'd8:    r = '{-2'sd1,  2'sd0,  2'sd0, WCLS_FACE};
            5'd9:    r = '{ 2'sd0,  2'sd0,  2'sd0, WCLS_REST};
            5'd10:   r = '{ 2'sd1,  2'sd0,  2'sd0, WCLS_FACE};
            5'd11:   r = '{-2'sd1,  2'sd1,  2'sd0, WCLS_EDGE};
            5'd12:   r = '{ 2'sd0,  2'sd1,  2'sd0, WCLS_FACE};
            5'd13:   r = '{ 2'sd1,  2'sd1,  2'sd0, WCLS_EDGE};
            5'd14:   r = '{ 2'sd0, -2'sd1,  2'sd1, WCLS_EDGE};
            5'd15:   r = '{-2'sd1,  2'sd0,  2'sd1, WCLS_EDGE};
            5'd16:   r = '{ 2'sd0,  2'sd0,  2'sd1, WCLS_FACE};
            5'd17:   r = '{ 2'sd1,  2'sd0,  2'sd1, WCLS_EDGE};
            5'd18:   r = '{ 2'sd0,  2'sd1,  2'sd1, WCLS_EDGE};
            default: r = '{ 2'sd0,  2'sd0,  2'sd0, WCLS_REST};
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction
endpackage
`default_nettype wire

FILE: hdl/lbm_mulq.sv
// Shared Q-format multiplier: 32x32 signed product registered, then
// round half up and saturate. Depends on lbm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbm_mulq (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [31:0]      o_q
);
    import lbm_pkg::*;
    logic signed [63:0] r_prod;
    logic signed [65:0] w_rnd;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // arithmetic shift of p + half floors, which is round half up
    assign w_rnd = (66'(r_prod) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign o_q   = sat32(w_rnd);
endmodule
`default_nettype wire

FILE: hdl/lbm_div.sv
// Restoring divider, one quotient bit per cycle: m / rho in Q form, divided as |m|
// with the sign put back, truncated and saturated. Depends on lbm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbm_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [lbm_pkg::SUM_W-1:0] i_num,
    input  wire logic signed [lbm_pkg::SUM_W-1:0] i_den,
    output logic                               o_done,
    output logic signed [31:0]                 o_quo
);
    import lbm_pkg::*;
    localparam int STEPS = SUM_W + FRAC_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [STEPS-1:0]   r_num, n_num;
    logic [SUM_W:0]     r_rem, n_rem;
    logic [STEPS-1:0]   r_quo, n_quo;
    logic [SUM_W-1:0]   r_den;
    logic               r_neg;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic [SUM_W:0]     w_trial;
    logic [SUM_W-1:0]   w_abs;

    assign w_abs   = i_num[SUM_W-1] ? SUM_W'(-i_num) : i_num;
    assign w_trial = {r_rem[SUM_W-1:0], r_num[STEPS-1]};

    always_comb begin
        n_num = r_num << 1;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_quo = {r_quo[STEPS-2:0], 1'b1};
        end else begin
            n_rem = w_trial;
            n_quo = {r_quo[STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(STEPS);
            r_num  <= {w_abs, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_quo  <= '0;
            r_den  <= i_den;
            r_neg  <= i_num[SUM_W-1];
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    logic w_ovf;
    assign w_ovf  = |r_quo[STEPS-1:31];
    assign o_done = r_busy && (r_cnt == '0) ? 1'b0 : (!r_busy && r_cnt == '0);
    always_comb begin
        if (w_ovf) o_quo = r_neg ? 32'sh80000000 : 32'sh7fffffff;
        else       o_quo = r_neg ? -$signed({1'b0, r_quo[30:0]})
                                 : $signed({1'b0, r_quo[30:0]});
    end
endmodule
`default_nettype wire

FILE: hdl/lbm_d3q19_cell_equilibrium.sv
// Top level of the D3Q19 equilibrium block: loader, sequencer, one shared
// multiplier (lbm_mulq) and one divider (lbm_div). Depends on lbm_pkg.
// Sequence: 19 load transactions; the 19th starts three serial divides, then u.u
//   and the base term, then one result per direction; the divides are skipped
//   when the density is not positive, and the velocity is then zero.
// One cell at a time: busy from the 19th load until the last result; loads are
//   taken only while not busy.
// Reset: synchronous active low; sums, count and state clear, registers default.
// Results stand for one cycle under o_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module lbm_d3q19_cell_equilibrium (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_dist_value,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [30:0]        i_cfg_data,
    output logic                    o_valid,
    output logic signed [31:0]      o_feq_value,
    output logic [4:0]              o_direction,
    output logic signed [31:0]      o_cell_density,
    output logic signed [31:0]      o_velocity_x,
    output logic signed [31:0]      o_velocity_y,
    output logic signed [31:0]      o_velocity_z,
    output logic                    o_bad_density,
    output logic                    o_last_of_cell
);
    import lbm_pkg::*;

    t_state r_state, n_state;
    logic [W_W-1:0] r_w_rest, r_w_face, r_w_edge;
    logic [K_W-1:0] r_k;
    logic [4:0] r_cnt;
    logic signed [SUM_W-1:0] r_rho, r_mx, r_my, r_mz;
    logic signed [31:0] r_u [3];
    logic [1:0] r_ax;      // axis / term index in multi-step states
    logic [2:0] r_ph;      // phase within a step waiting on the multiplier
    logic signed [31:0] r_acc, r_base, r_cu, r_poly, r_wr, r_feq;
    logic signed [31:0] r_rho32;
    logic r_bad, r_dstart;
    logic r_dwait;

    logic signed [31:0] w_ma, w_mb, w_mq;
    logic w_ddone;
    logic signed [31:0] w_dq;
    logic signed [SUM_W-1:0] w_dnum;
    t_dir w_dir;
    logic signed [33:0] w_dot;
    logic [W_W-1:0] w_wsel;

    lbm_mulq u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_q(w_mq));
    lbm_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
                   .i_num(w_dnum), .i_den(r_rho), .o_done(w_ddone), .o_quo(w_dq));

    assign w_dnum = (r_ax == 2'd0) ? r_mx : (r_ax == 2'd1) ? r_my : r_mz;
    assign w_dir  = dir_vec(r_cnt);
    always_comb begin
        case (w_dir.wcls)
            WCLS_REST: w_wsel = r_w_rest;
            WCLS_FACE: w_wsel = r_w_face;
            default:   w_wsel = r_w_edge;
        endcase
    end
    assign w_dot = 34'(w_dir.cx) * 34'(r_u[0]) + 34'(w_dir.cy) * 34'(r_u[1])
                 + 34'(w_dir.cz) * 34'(r_u[2]);

    // multiplier operand select
    always_comb begin
        case (r_state)
            ST_UU:   begin w_ma = r_u[r_ax]; w_mb = r_u[r_ax]; end
            ST_BASE: begin w_ma = r_acc; w_mb = $signed({1'b0, r_k}); end
            ST_CU:   begin w_ma = r_acc; w_mb = $signed({1'b0, r_k}); end
            ST_CU2:  begin w_ma = r_cu; w_mb = r_cu; end
            ST_WR:   begin w_ma = $signed({3'b0, w_wsel}); w_mb = r_rho32; end
            ST_FEQ:  begin w_ma = r_wr; w_mb = r_poly; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign busy = (r_state != ST_LOAD);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: if (start && r_cnt == 5'd18)
                         n_state = (r_rho + SUM_W'(i_dist_value) <= 0) ? ST_UU : ST_DIV;
            ST_DIV:  if (r_dwait && w_ddone && r_ax == 2'd2) n_state = ST_UU;
            ST_UU:   if (r_ph == 3'd1 && r_ax == 2'd2) n_state = ST_BASE;
            ST_BASE: if (r_ph == 3'd1) n_state = ST_DOT;
            ST_DOT:  n_state = ST_CU;
            ST_CU:   if (r_ph == 3'd1) n_state = ST_CU2;
            ST_CU2:  if (r_ph == 3'd1) n_state = ST_POLY;
            ST_POLY: n_state = ST_WR;
            ST_WR:   if (r_ph == 3'd1) n_state = ST_FEQ;
            ST_FEQ:  if (r_ph == 3'd1) n_state = ST_EMIT;
            ST_EMIT: n_state = (r_cnt == 5'd18) ? ST_LOAD : ST_DOT;
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_valid        = (r_state == ST_EMIT);
        o_feq_value    = r_feq;
        o_direction    = r_cnt;
        o_cell_density = r_rho32;
        o_velocity_x   = r_u[0];
        o_velocity_y   = r_u[1];
        o_velocity_z   = r_u[2];
        o_bad_density  = r_bad;
        o_last_of_cell = (r_cnt == 5'd18);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_cnt    <= '0;
            r_rho    <= '0; r_mx <= '0; r_my <= '0; r_mz <= '0;
            r_w_rest <= W_W'(89478485);
            r_w_face <= W_W'(14913081);
            r_w_edge <= W_W'(7456540);
            r_k      <= K_W'(805306368);
            r_ph     <= '0; r_ax <= '0;
            r_dstart <= 1'b0; r_dwait <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dstart <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_W_REST: r_w_rest <= i_cfg_data[W_W-1:0];
                    CFG_W_FACE: r_w_face <= i_cfg_data[W_W-1:0];
                    CFG_W_EDGE: r_w_edge <= i_cfg_data[W_W-1:0];
                    CFG_INV_CS: r_k      <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_LOAD: if (start) begin
                    r_rho <= r_rho + SUM_W'(i_dist_value);
                    r_mx  <= r_mx + SUM_W'(w_dir.cx) * SUM_W'(i_dist_value);
                    r_my  <= r_my + SUM_W'(w_dir.cy) * SUM_W'(i_dist_value);
                    r_mz  <= r_mz + SUM_W'(w_dir.cz) * SUM_W'(i_dist_value);
                    if (r_cnt == 5'd18) begin
                        r_cnt <= '0; r_ax <= '0; r_ph <= '0; r_acc <= '0;
                        r_bad <= (r_rho + SUM_W'(i_dist_value) <= 0);
                        r_rho32 <= sat32(66'(r_rho + SUM_W'(i_dist_value)));
                        r_u[0] <= '0; r_u[1] <= '0; r_u[2] <= '0;
                        if (!(r_rho + SUM_W'(i_dist_value) <= 0)) r_dstart <= 1'b1;
                        r_dwait <= 1'b0;
                    end else r_cnt <= r_cnt + 1'b1;
                end
                ST_DIV: begin
                    r_dwait <= 1'b1;
                    if (r_dwait && w_ddone) begin
                        r_u[r_ax] <= w_dq;
                        r_dwait   <= 1'b0;
                        if (r_ax == 2'd2) r_ax <= '0;
                        else begin r_ax <= r_ax + 1'b1; r_dstart <= 1'b1; end
                    end
                end
                ST_UU: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 3'd1) begin
                        r_ph  <= '0;
                        r_acc <= sat32(66'(r_acc) + 66'(w_mq));
                        r_ax  <= (r_ax == 2'd2) ? 2'd0 : r_ax + 1'b1;
                    end
                end
                ST_BASE: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 3'd1) begin
                        r_ph   <= '0;
                        r_base <= sat32((66'sd1 <<< FRAC_BITS) - (66'(w_mq) >>> 1));
                    end
                end
                ST_DOT:  r_acc <= sat32(66'(w_dot));
                ST_CU: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 3'd1) begin r_ph <= '0; r_cu <= w_mq; end
                end
                ST_CU2: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 3'd1) begin
                        r_ph   <= '0;
                        r_poly <= sat32(66'(r_base) + 66'(r_cu) + (66'(w_mq) >>> 1));
                    end
                end
                ST_WR: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 3'd1) begin r_ph <= '0; r_wr <= w_mq; end
                end
                ST_FEQ: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 3'd1) begin r_ph <= '0; r_feq <= w_mq; end
                end
                ST_EMIT: begin
                    if (r_cnt == 5'd18) begin
                        r_cnt <= '0;
                        r_rho <= '0; r_mx <= '0; r_my <= '0; r_mz <= '0;
                    end else r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/lbm_checker.sv
// Port-level checker for the equilibrium block, bound to the top level.
// Depends on lbm_pkg only through the bound module.
`timescale 1ns / 1ps
`default_nettype none
module lbm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic [4:0] o_direction,
    input wire logic       o_last_of_cell,
    input wire logic       o_bad_density,
    input wire logic [31:0] o_velocity_x
);
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside busy");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_cell == (o_direction == 5'd18)))
        else $error("last flag wrong");
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_direction <= 5'd18) else $error("direction range");
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_density) |-> o_velocity_x == 32'd0)
        else $error("velocity not zero on bad density");
endmodule
bind lbm_d3q19_cell_equilibrium lbm_checker u_chk (.*);
`default_nettype wire

FILE: dv/tb_lbm_d3q19_cell_equilibrium.sv
// Self-checking testbench for lbm_d3q19_cell_equilibrium: feeds whole cells of
// 19 distributions, predicts the 19 equilibrium results per cell, checks them.
// Depends on lbm_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_lbm_d3q19_cell_equilibrium;
    import lbm_pkg::*;

    localparam longint Q_MAX    = 64'sd2147483647;
    localparam longint Q_MIN    = -64'sd2147483648;
    localparam longint Q_ONE    = 64'sd1 << FRAC_BITS;
    localparam int     IDLE_CAP = 3000;

    typedef struct {
        longint feq;
        int     dir;
        longint rho;
        longint vx, vy, vz;
        bit     bad;
        bit     last;
    } t_feq_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [31:0] i_dist_value = '0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = CFG_W_REST;
    logic [30:0] i_cfg_data = '0;
    logic busy, o_valid, o_bad_density, o_last_of_cell;
    logic signed [31:0] o_feq_value, o_cell_density;
    logic signed [31:0] o_velocity_x, o_velocity_y, o_velocity_z;
    logic [4:0] o_direction;

    lbm_d3q19_cell_equilibrium dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lattice vectors and weight classes, direction 9 at rest
    int lat_cx[NDIR] = '{ 0,-1, 0, 1, 0,-1, 0, 1,-1, 0, 1,-1, 0, 1, 0,-1, 0, 1, 0};
    int lat_cy[NDIR] = '{-1, 0, 0, 0, 1,-1,-1,-1, 0, 0, 0, 1, 1, 1,-1, 0, 0, 0, 1};
    int lat_cz[NDIR] = '{-1,-1,-1,-1,-1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1};
    int lat_cls[NDIR] = '{2, 2, 1, 2, 2, 2, 1, 2, 1, 0, 1, 2, 1, 2, 2, 2, 1, 2, 2};

    longint w_rest = 89478485, w_face = 14913081, w_edge = 7456540, inv_cs2 = 805306368;
    int     cell_fill = 0;
    longint rho_acc = 0;
    longint mom_acc[3] = '{0, 0, 0};

    logic signed [31:0] dist_pending[$];
    t_feq_result        feq_expected[$];
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0, gap_left = 0;

    function automatic longint clamp_q(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // Q product, ties toward +inf, floor of the shifted sum
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
        return clamp_q(p >>> FRAC_BITS);
    endfunction

    // momentum / density, truncated toward zero, saturated
    function automatic longint qdiv(longint m, longint rho);
        longint unsigned am, ar, qi, r, q;
        bit neg;
        neg = m < 0;
        am = neg ? longint'(-m) : m;
        ar = rho;
        qi = am / ar;
        r = am % ar;
        if ((qi >> (31 - FRAC_BITS)) != 0) return neg ? Q_MIN : Q_MAX;
        q = (qi << FRAC_BITS) | ((r << FRAC_BITS) / ar);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    task automatic take_distribution(longint f);
        longint u[3];
        longint rho, uu, base, dot, cu, poly, w;
        bit bad;
        t_feq_result e;
        rho_acc += f;
        for (int c = 0; c < 3; c++) begin
            mom_acc[c] += f * (c == 0 ? lat_cx[cell_fill] :
                               c == 1 ? lat_cy[cell_fill] : lat_cz[cell_fill]);
        end
        if (cell_fill < NDIR - 1) begin
            cell_fill++;
            return;
        end
        bad = rho_acc <= 0;
        for (int c = 0; c < 3; c++) u[c] = bad ? 0 : qdiv(mom_acc[c], rho_acc);
        rho = clamp_q(rho_acc);
        uu = clamp_q(qmul(u[0], u[0]) + qmul(u[1], u[1]) + qmul(u[2], u[2]));
        base = clamp_q(Q_ONE - (qmul(uu, inv_cs2) >>> 1));
        for (int d = 0; d < NDIR; d++) begin
            dot = lat_cx[d] * u[0] + lat_cy[d] * u[1] + lat_cz[d] * u[2];
            cu = qmul(clamp_q(dot), inv_cs2);
            poly = clamp_q(base + cu + (qmul(cu, cu) >>> 1));
            w = lat_cls[d] == 0 ? w_rest : lat_cls[d] == 1 ? w_face : w_edge;
            e.feq = qmul(qmul(w, rho), poly);
            e.dir = d;
            e.rho = rho;
            e.vx = u[0];
            e.vy = u[1];
            e.vz = u[2];
            e.bad = bad;
            e.last = d == NDIR - 1;
            feq_expected.push_back(e);
        end
        cell_fill = 0;
        rho_acc = 0;
        mom_acc = '{0, 0, 0};
    endtask

    // driver: bursts with random gaps, start held while busy
    always @(posedge i_clk) begin : drv
        bit drive;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drive = start && busy;
            if (start && !busy) begin
                take_distribution(longint'(i_dist_value));
                void'(dist_pending.pop_front());
            end
            if (!drive) begin
                if (dist_pending.size() > 0 && burst_left > 0) begin
                    drive = 1'b1;
                    burst_left--;
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            drive = drive && dist_pending.size() > 0;
            if (drive) i_dist_value <= dist_pending[0];
            start <= drive;
        end
    end

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // monitor and watchdog
    always @(posedge i_clk) begin : mon
        t_feq_result e;
        if (i_rst_n) begin
            if (o_valid) begin
                if (feq_expected.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual dir %0d feq %0d",
                             $time, o_direction, o_feq_value);
                    errors++;
                end else begin
                    e = feq_expected.pop_front();
                    check_field("feq_value", e.feq, longint'(o_feq_value));
                    check_field("direction", e.dir, longint'(o_direction));
                    check_field("cell_density", e.rho, longint'(o_cell_density));
                    check_field("velocity_x", e.vx, longint'(o_velocity_x));
                    check_field("velocity_y", e.vy, longint'(o_velocity_y));
                    check_field("velocity_z", e.vz, longint'(o_velocity_z));
                    check_field("bad_density", e.bad, longint'(o_bad_density));
                    check_field("last_of_cell", e.last, longint'(o_last_of_cell));
                end
            end
            if (o_valid || (start && !busy)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_CAP) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_W_REST: w_rest = data[28:0];
            CFG_W_FACE: w_face = data[28:0];
            CFG_W_EDGE: w_edge = data[28:0];
            CFG_INV_CS: inv_cs2 = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [30:0] wr, logic [30:0] wf, logic [30:0] we,
                             logic [30:0] k);
        write_reg(CFG_W_REST, wr);
        write_reg(CFG_W_FACE, wf);
        write_reg(CFG_W_EDGE, we);
        write_reg(CFG_INV_CS, k);
    endtask

    task automatic push_dist(logic signed [31:0] f);
        @(negedge i_clk);
        dist_pending.push_back(f);
    endtask

    // kinds: 0 near equilibrium, 1 raw noise, 2 negative, 3 thin cell with strong flow
    task automatic push_random_cell(int kind);
        longint rho0, w, f;
        rho0 = $urandom_range(1 << 26, 1 << 29);
        for (int d = 0; d < NDIR; d++) begin
            w = lat_cls[d] == 0 ? 89478485 : lat_cls[d] == 1 ? 14913081 : 7456540;
            case (kind)
                0: f = ((w * rho0) >>> FRAC_BITS) + $urandom_range(0, 1 << 23) - (1 << 22);
                1: f = $signed($urandom());
                2: f = -longint'($urandom_range(0, 1 << 27));
                default: f = (d == 9) ? $urandom_range(1, 1 << 20)
                             : $signed($urandom()) >>> $urandom_range(0, 8);
            endcase
            push_dist(f[31:0]);
        end
    endtask

    task automatic drain;
        while (dist_pending.size() > 0 || feq_expected.size() > 0 || busy || start)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_cells(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            push_random_cell(r < 6 ? 0 : r < 8 ? 1 : r < 9 ? 2 : 3);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // thin positive density with huge x momentum: velocity saturates
        for (int d = 0; d < NDIR; d++)
            push_dist(d == 10 ? 32'sh7fffffff : d == 8 ? 32'sh80000001 :
                      d == 9 ? 32'sd1 : 32'sd0);
        // density beyond range saturates
        for (int d = 0; d < NDIR; d++) push_dist(32'sh7fffffff);
        // most negative inputs, and an all-zero cell: both flag bad density
        for (int d = 0; d < NDIR; d++) push_dist(32'sh80000000);
        for (int d = 0; d < NDIR; d++) push_dist(32'sd0);
        push_random_cell(0);
        random_cells(2);
        drain();

        write_all(31'd268435456, 31'd268435456, 31'd268435456, 31'h7fffffff);
        random_cells(4);
        drain();
        write_all(31'd0, 31'd0, 31'd0, 31'd0);
        random_cells(3);
        drain();
        // bits above the weight width are dropped
        write_all(31'h7fffffff, 31'h6000_0001, 31'h5555_5555, 31'd268435456);
        random_cells(3);
        drain();
        for (int p = 0; p < 2; p++) begin
            write_all($urandom_range(0, 268435456), $urandom_range(0, 268435456),
                      $urandom_range(0, 268435456), $urandom_range(0, 32'h7fffffff));
            random_cells(3);
            drain();
        end
        write_all(31'd89478485, 31'd14913081, 31'd7456540, 31'd805306368);
        random_cells(2);
        drain();
        repeat (600) @(posedge i_clk);

        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
